@@ rtl/core/shared_pool_multi_queue_defines.svh @@
// Assertion macros used by the checker file of the shared pool queue block.
`ifndef SHARED_POOL_MULTI_QUEUE_DEFINES_SVH
`define SHARED_POOL_MULTI_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and quiet during reset.
`define SPMQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and quiet during reset.
`define SPMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/spmq_pkg.sv @@
// Types, codes and default sizes shared by the shared pool queue modules.
package spmq_pkg;

    localparam int QUEUES_DEF       = 16;
    localparam int POOL_ENTRIES_DEF = 1024;
    localparam int ITEM_BITS_DEF    = 64;

    localparam logic [4:0] NQ_RESET = 5'd16;

    localparam logic ACT_ENTER = 1'b0;
    localparam logic ACT_LEAVE = 1'b1;

    typedef enum logic [2:0] {
        ST_ENTERED   = 3'd0,
        ST_LEFT      = 3'd1,
        ST_BAD_QUEUE = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_LINK,
        S_POP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic item_we;
        logic link_we;
    } t_pool_cmd;

    typedef struct packed {
        logic rd_en;
        logic ptr_we;
        logic ne_we;
        logic ne_val;
    } t_qtab_cmd;

endpackage

@@ rtl/core/spmq_pool.sv @@
// Shared entry pool: token memory and link memory with one registered read port.
module spmq_pool #(
    parameter int   POOL_ENTRIES = spmq_pkg::POOL_ENTRIES_DEF,
    parameter int   ITEM_BITS    = spmq_pkg::ITEM_BITS_DEF,
    localparam int  IDX_W        = $clog2(POOL_ENTRIES)
) (
    input  logic                     i_clk,
    input  spmq_pkg::t_pool_cmd      i_cmd,
    input  logic [IDX_W-1:0]         i_rd_addr,
    input  logic [IDX_W-1:0]         i_wr_addr,
    input  logic [ITEM_BITS-1:0]     i_item_data,
    input  logic [IDX_W-1:0]         i_link_data,
    output logic [ITEM_BITS-1:0]     o_item,
    output logic [IDX_W-1:0]         o_link
);

    logic [ITEM_BITS-1:0] r_item_mem [POOL_ENTRIES];
    logic [IDX_W-1:0]     r_link_mem [POOL_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_cmd.item_we) begin
            r_item_mem[i_wr_addr] <= i_item_data;
        end
        if (i_cmd.rd_en) begin
            o_item <= r_item_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.link_we) begin
            r_link_mem[i_wr_addr] <= i_link_data;
        end
        if (i_cmd.rd_en) begin
            o_link <= r_link_mem[i_rd_addr];
        end
    end

endmodule

@@ rtl/core/spmq_qtab.sv @@
// Per-queue head and tail pointer memory plus the non-empty flag of each queue.
module spmq_qtab #(
    parameter int   QUEUES       = spmq_pkg::QUEUES_DEF,
    parameter int   POOL_ENTRIES = spmq_pkg::POOL_ENTRIES_DEF,
    localparam int  IDX_W        = $clog2(POOL_ENTRIES),
    localparam int  QIDX_W       = (QUEUES > 1) ? $clog2(QUEUES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  spmq_pkg::t_qtab_cmd  i_cmd,
    input  logic [QIDX_W-1:0]    i_rd_idx,
    input  logic [QIDX_W-1:0]    i_wr_idx,
    input  logic [IDX_W-1:0]     i_wr_head,
    input  logic [IDX_W-1:0]     i_wr_tail,
    output logic [IDX_W-1:0]     o_head,
    output logic [IDX_W-1:0]     o_tail,
    output logic                 o_nonempty
);

    logic [2*IDX_W-1:0] r_ptr_mem [QUEUES];
    logic [QUEUES-1:0]  r_ne;
    logic [QUEUES-1:0]  n_ne;

    // Pointers of an empty queue are never used, so only the flags need reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ptr_we) begin
            r_ptr_mem[i_wr_idx] <= {i_wr_head, i_wr_tail};
        end
        if (i_cmd.rd_en) begin
            {o_head, o_tail} <= r_ptr_mem[i_rd_idx];
        end
    end

    always_comb begin
        n_ne = r_ne;
        if (i_cmd.ne_we) begin
            n_ne[i_wr_idx] = i_cmd.ne_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ne       <= '0;
            o_nonempty <= 1'b0;
        end else begin
            r_ne <= n_ne;
            if (i_cmd.rd_en) begin
                o_nonempty <= r_ne[i_rd_idx];
            end
        end
    end

endmodule

@@ rtl/core/spmq_ctrl.sv @@
// Sequencer: queue checks, free list and fresh counter, result register.
module spmq_ctrl #(
    parameter int   QUEUES       = spmq_pkg::QUEUES_DEF,
    parameter int   POOL_ENTRIES = spmq_pkg::POOL_ENTRIES_DEF,
    parameter int   ITEM_BITS    = spmq_pkg::ITEM_BITS_DEF,
    localparam int  IDX_W        = $clog2(POOL_ENTRIES),
    localparam int  QIDX_W       = (QUEUES > 1) ? $clog2(QUEUES) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_action,
    input  logic [7:0]           i_queue_number,
    input  logic [63:0]          i_item_name,
    input  logic [4:0]           i_number_of_queues,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_status,
    output logic [63:0]          o_front_item,
    output spmq_pkg::t_qtab_cmd  o_qt_cmd,
    output logic [QIDX_W-1:0]    o_qt_rd_idx,
    output logic [QIDX_W-1:0]    o_qt_wr_idx,
    output logic [IDX_W-1:0]     o_qt_wr_head,
    output logic [IDX_W-1:0]     o_qt_wr_tail,
    input  logic [IDX_W-1:0]     i_qt_head,
    input  logic [IDX_W-1:0]     i_qt_tail,
    input  logic                 i_qt_ne,
    output spmq_pkg::t_pool_cmd  o_pool_cmd,
    output logic [IDX_W-1:0]     o_pool_rd_addr,
    output logic [IDX_W-1:0]     o_pool_wr_addr,
    output logic [IDX_W-1:0]     o_pool_link_data,
    output logic [ITEM_BITS-1:0] o_pool_item_data,
    input  logic [ITEM_BITS-1:0] i_pool_item,
    input  logic [IDX_W-1:0]     i_pool_link
);

    localparam logic [8:0]     QN_MAX   = 9'(QUEUES);
    localparam logic [IDX_W:0] POOL_CNT = (IDX_W+1)'(POOL_ENTRIES);

    spmq_pkg::t_state  r_state, n_state;
    spmq_pkg::t_status r_status, n_status;
    spmq_pkg::t_status r_o_status, n_o_status;
    logic                 r_action, n_action;
    logic [QIDX_W-1:0]    r_qidx, n_qidx;
    logic [ITEM_BITS-1:0] r_name, n_name;
    logic [IDX_W-1:0]     r_entry, n_entry;
    logic [ITEM_BITS-1:0] r_front, n_front;
    logic [IDX_W:0]       r_fresh, n_fresh;
    logic [IDX_W-1:0]     r_free_head, n_free_head;
    logic                 r_free_ne, n_free_ne;
    logic                 r_o_valid, n_o_valid;
    logic [ITEM_BITS-1:0] r_o_front, n_o_front;

    logic              in_bad;
    logic [QIDX_W-1:0] in_qidx;
    logic [IDX_W-1:0]  e_sel;

    assign in_bad  = (i_queue_number == 8'd0)
                  || ({1'b0, i_queue_number} > {4'd0, i_number_of_queues})
                  || ({1'b0, i_queue_number} > QN_MAX);
    assign in_qidx = QIDX_W'(i_queue_number - 8'd1);
    // A released entry is reused before a fresh one.
    assign e_sel   = r_free_ne ? r_free_head : r_fresh[IDX_W-1:0];

    assign o_ready      = (r_state == spmq_pkg::S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_front_item = 64'(r_o_front);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spmq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_status    = r_status;
        n_o_status  = r_o_status;
        n_action    = r_action;
        n_qidx      = r_qidx;
        n_name      = r_name;
        n_entry     = r_entry;
        n_front     = r_front;
        n_fresh     = r_fresh;
        n_free_head = r_free_head;
        n_free_ne   = r_free_ne;
        n_o_valid   = r_o_valid;
        n_o_front   = r_o_front;

        o_qt_cmd         = '0;
        o_qt_rd_idx      = in_qidx;
        o_qt_wr_idx      = r_qidx;
        o_qt_wr_head     = i_qt_head;
        o_qt_wr_tail     = i_qt_tail;
        o_pool_cmd       = '0;
        o_pool_rd_addr   = r_free_head;
        o_pool_wr_addr   = e_sel;
        o_pool_link_data = e_sel;
        o_pool_item_data = r_name;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            spmq_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_action = i_action;
                    n_qidx   = in_qidx;
                    n_name   = ITEM_BITS'(i_item_name);
                    n_front  = '0;
                    if (in_bad) begin
                        n_status = spmq_pkg::ST_BAD_QUEUE;
                        n_state  = spmq_pkg::S_DONE;
                    end else begin
                        // Fetch the queue pointers and the free-list successor together.
                        o_qt_cmd.rd_en   = 1'b1;
                        o_pool_cmd.rd_en = 1'b1;
                        n_state          = spmq_pkg::S_LOOK;
                    end
                end
            end
            spmq_pkg::S_LOOK: begin
                if (r_action == spmq_pkg::ACT_ENTER) begin
                    if (!r_free_ne && (r_fresh == POOL_CNT)) begin
                        n_status = spmq_pkg::ST_FULL;
                        n_state  = spmq_pkg::S_DONE;
                    end else begin
                        if (r_free_ne) begin
                            if (i_pool_link == r_free_head) begin
                                n_free_ne = 1'b0;
                            end else begin
                                n_free_head = i_pool_link;
                            end
                        end else begin
                            n_fresh = r_fresh + 1'b1;
                        end
                        o_pool_cmd.item_we = 1'b1;
                        o_pool_cmd.link_we = 1'b1;
                        o_qt_cmd.ptr_we    = 1'b1;
                        o_qt_cmd.ne_we     = 1'b1;
                        o_qt_cmd.ne_val    = 1'b1;
                        o_qt_wr_head       = i_qt_ne ? i_qt_head : e_sel;
                        o_qt_wr_tail       = e_sel;
                        n_entry            = e_sel;
                        n_status           = spmq_pkg::ST_ENTERED;
                        n_state            = i_qt_ne ? spmq_pkg::S_LINK : spmq_pkg::S_DONE;
                    end
                end else begin
                    if (!i_qt_ne) begin
                        n_status = spmq_pkg::ST_EMPTY;
                        n_state  = spmq_pkg::S_DONE;
                    end else begin
                        o_pool_cmd.rd_en = 1'b1;
                        o_pool_rd_addr   = i_qt_head;
                        n_state          = spmq_pkg::S_POP;
                    end
                end
            end
            spmq_pkg::S_LINK: begin
                // Old tail now points at the new entry.
                o_pool_cmd.link_we = 1'b1;
                o_pool_wr_addr     = i_qt_tail;
                o_pool_link_data   = r_entry;
                n_state            = spmq_pkg::S_DONE;
            end
            spmq_pkg::S_POP: begin
                n_front = i_pool_item;
                if (i_qt_head == i_qt_tail) begin
                    o_qt_cmd.ne_we  = 1'b1;
                    o_qt_cmd.ne_val = 1'b0;
                end else begin
                    o_qt_cmd.ptr_we = 1'b1;
                    o_qt_wr_head    = i_pool_link;
                end
                // Push the released entry onto the free list.
                o_pool_cmd.link_we = 1'b1;
                o_pool_wr_addr     = i_qt_head;
                o_pool_link_data   = r_free_ne ? r_free_head : i_qt_head;
                n_free_head        = i_qt_head;
                n_free_ne          = 1'b1;
                n_status           = spmq_pkg::ST_LEFT;
                n_state            = spmq_pkg::S_DONE;
            end
            spmq_pkg::S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_front  = r_front;
                    n_state    = spmq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = spmq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh     <= '0;
            r_free_head <= '0;
            r_free_ne   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_fresh     <= n_fresh;
            r_free_head <= n_free_head;
            r_free_ne   <= n_free_ne;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_action   <= n_action;
        r_qidx     <= n_qidx;
        r_name     <= n_name;
        r_entry    <= n_entry;
        r_front    <= n_front;
        r_o_front  <= n_o_front;
    end

endmodule

@@ rtl/core/shared_pool_multi_queue.sv @@
// Several FIFO queues that share one linked pool of entries.
//
// Input channel (i_valid / o_ready) carries an action, a one-based queue number and
// a name token. Enter appends the token to that queue; leave removes the queue's
// front entry and returns its token. Every item gives exactly one result on the
// output channel (o_valid / i_ready): a status code and the removed token, zero
// unless the status is "left".
// An item with a bad queue number goes straight to its result; a leave on an empty
// queue, an enter into an empty queue or an enter into a full pool first looks up
// the queue's pointers; an enter into a non-empty queue then also links the old
// tail, and a successful leave also reads and releases the front entry.
// These steps are set by the registered reads of the pointer and pool memories and
// by the single write port of the link memory, which an enter into a non-empty
// queue uses twice. One item is in work at a time.
// The result sits in an output register; the next item is accepted while it
// waits, and the finished result of that item waits until the receiver drains it.
// Reset empties every queue, the free list and the pool and sets the queue
// count register to 16; no memory clearing pass is needed.
// The APB port holds one register at address 0: the number of queues in use.
module shared_pool_multi_queue #(
    parameter int QUEUES       = spmq_pkg::QUEUES_DEF,
    parameter int POOL_ENTRIES = spmq_pkg::POOL_ENTRIES_DEF,
    parameter int ITEM_BITS    = spmq_pkg::ITEM_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_queue_number,
    input  logic [63:0] i_item_name,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [63:0] o_front_item
);

    localparam int IDX_W  = $clog2(POOL_ENTRIES);
    localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    logic [4:0] r_nq;

    spmq_pkg::t_qtab_cmd  qt_cmd;
    spmq_pkg::t_pool_cmd  pool_cmd;
    logic [QIDX_W-1:0]    qt_rd_idx;
    logic [QIDX_W-1:0]    qt_wr_idx;
    logic [IDX_W-1:0]     qt_wr_head;
    logic [IDX_W-1:0]     qt_wr_tail;
    logic [IDX_W-1:0]     qt_head;
    logic [IDX_W-1:0]     qt_tail;
    logic                 qt_ne;
    logic [IDX_W-1:0]     pool_rd_addr;
    logic [IDX_W-1:0]     pool_wr_addr;
    logic [IDX_W-1:0]     pool_link_data;
    logic [ITEM_BITS-1:0] pool_item_data;
    logic [ITEM_BITS-1:0] pool_item;
    logic [IDX_W-1:0]     pool_link;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {27'd0, r_nq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nq <= spmq_pkg::NQ_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_nq <= pwdata[4:0];
        end
    end

    spmq_ctrl #(
        .QUEUES       (QUEUES),
        .POOL_ENTRIES (POOL_ENTRIES),
        .ITEM_BITS    (ITEM_BITS)
    ) u_ctrl (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_action           (i_action),
        .i_queue_number     (i_queue_number),
        .i_item_name        (i_item_name),
        .i_number_of_queues (r_nq),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_front_item       (o_front_item),
        .o_qt_cmd           (qt_cmd),
        .o_qt_rd_idx        (qt_rd_idx),
        .o_qt_wr_idx        (qt_wr_idx),
        .o_qt_wr_head       (qt_wr_head),
        .o_qt_wr_tail       (qt_wr_tail),
        .i_qt_head          (qt_head),
        .i_qt_tail          (qt_tail),
        .i_qt_ne            (qt_ne),
        .o_pool_cmd         (pool_cmd),
        .o_pool_rd_addr     (pool_rd_addr),
        .o_pool_wr_addr     (pool_wr_addr),
        .o_pool_link_data   (pool_link_data),
        .o_pool_item_data   (pool_item_data),
        .i_pool_item        (pool_item),
        .i_pool_link        (pool_link)
    );

    spmq_qtab #(
        .QUEUES       (QUEUES),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_qtab (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (qt_cmd),
        .i_rd_idx   (qt_rd_idx),
        .i_wr_idx   (qt_wr_idx),
        .i_wr_head  (qt_wr_head),
        .i_wr_tail  (qt_wr_tail),
        .o_head     (qt_head),
        .o_tail     (qt_tail),
        .o_nonempty (qt_ne)
    );

    spmq_pool #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .ITEM_BITS    (ITEM_BITS)
    ) u_pool (
        .i_clk       (i_clk),
        .i_cmd       (pool_cmd),
        .i_rd_addr   (pool_rd_addr),
        .i_wr_addr   (pool_wr_addr),
        .i_item_data (pool_item_data),
        .i_link_data (pool_link_data),
        .o_item      (pool_item),
        .o_link      (pool_link)
    );

endmodule

@@ rtl/core/spmq_checker.sv @@
// Port-level checks of the shared pool queue block, bound to the top level.
`include "shared_pool_multi_queue_defines.svh"

module spmq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [63:0] o_front_item
);

    `SPMQ_ASSERT_NOW(a_status_code, o_valid, (o_status == spmq_pkg::ST_ENTERED) || (o_status == spmq_pkg::ST_LEFT) || (o_status == spmq_pkg::ST_BAD_QUEUE) || (o_status == spmq_pkg::ST_EMPTY) || (o_status == spmq_pkg::ST_FULL), "status code out of range")
    `SPMQ_ASSERT_NOW(a_front_zero, o_valid && (o_status != spmq_pkg::ST_LEFT), o_front_item == 64'd0, "token returned without a leave")
    `SPMQ_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready, "second item accepted while one is in work")
    `SPMQ_ASSERT_NEXT(a_result_held, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_front_item), "stalled result changed")

endmodule

bind shared_pool_multi_queue spmq_checker u_spmq_checker (.*);
